### hdl/skf_pkg.sv
// Shared types, widths and constants of the scalar Kalman estimator.
package skf_pkg;

  localparam int MEAS_W    = 16;
  localparam int GAIN_W    = 17;
  localparam int ERR_W     = 32;
  localparam int DEN_W     = ERR_W + 1;
  localparam int REM_W     = DEN_W + 1;
  localparam int DIFF_W    = MEAS_W + 1;
  localparam int MUL_A_W   = GAIN_W + 1;
  localparam int MUL_B_W   = ERR_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_STEPS = GAIN_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int FRAC_W    = 16;

  localparam logic [GAIN_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [ERR_W-1:0] MEAS_ERR_RESET   = 32'd589824;
  localparam logic [ERR_W-1:0] INIT_ERR_RESET   = 32'd65536;
  localparam logic [ERR_W-1:0] PROC_NOISE_RESET = 32'd4260;

  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_ERR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_ERR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_CORR,
    ST_EST,
    ST_MUL_DECAY,
    ST_MUL_NOISE,
    ST_DONE
  } skf_state_t;

endpackage

### hdl/skf_ifs.sv
// Channel interfaces of the scalar Kalman estimator: measurement, result and register write.
interface skf_in_if import skf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [MEAS_W-1:0] measurement;
  modport source(output valid, output measurement, input ready);
  modport sink(input valid, input measurement, output ready);
endinterface

interface skf_out_if import skf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [MEAS_W-1:0] estimate;
  logic        [GAIN_W-1:0] gain;
  logic        [ERR_W-1:0]  error_out;
  logic                     divide_fault;
  modport source(output valid, output estimate, output gain, output error_out,
                 output divide_fault, input ready);
  modport sink(input valid, input estimate, input gain, input error_out,
               input divide_fault, output ready);
endinterface

interface skf_cfg_if import skf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [ERR_W-1:0]     wdata;
  modport source(output valid, output reg_index, output wdata, input ready);
  modport sink(input valid, input reg_index, input wdata, output ready);
endinterface

### hdl/scalar_kalman_estimator_top.sv
// Scalar Kalman estimator: one measurement beat in, one estimate/gain/error beat out.
//
// Each accepted Q8.8 measurement runs through a small sequencer: a restoring
// divider produces the Q1.16 gain one quotient bit per cycle, then one
// shared 18x33 signed multiplier is used three times in turn, for the
// correction term, the error decay and the process noise term. The input
// takes no new beat until the last result is committed to the output
// register; in_ch.ready is low while an item is at work. The result sits in
// an output register, so the next measurement is taken while a finished
// result still waits; only a second result that finds the register full
// holds the sequencer. Register writes are always taken and should be made
// while the block is idle. Writing the initial error register loads the
// running error itself. A zero gain denominator forces the gain to 0 and
// raises divide_fault.
module scalar_kalman_estimator_top import skf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  skf_in_if.sink    in_ch,
  skf_out_if.source out_ch,
  skf_cfg_if.sink   cfg_ch
);

  // configuration registers; the initial error register only loads err_r
  logic [ERR_W-1:0] meas_err_r;
  logic [ERR_W-1:0] proc_noise_r;

  // filter state
  logic signed [MEAS_W-1:0] last_r;
  logic        [ERR_W-1:0]  err_r;

  // sequencer
  skf_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;

  // datapath
  logic signed [DIFF_W-1:0] diff_r;
  logic        [DEN_W-1:0]  denom_r;
  logic        [REM_W-1:0]  rem_r;
  logic        [GAIN_W-1:0] quo_r;
  logic                     fault_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [MEAS_W-1:0] est_r;
  logic        [DIFF_W-1:0] absd_r;
  logic        [ERR_W-1:0]  decay_r;

  // output register
  logic                     out_valid_r;
  logic signed [MEAS_W-1:0] out_est_r;
  logic        [GAIN_W-1:0] out_gain_r;
  logic        [ERR_W-1:0]  out_err_r;
  logic                     out_fault_r;

  logic in_fire;
  logic out_free;
  logic commit;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  logic [GAIN_W-1:0] gain_w;
  logic [DEN_W-1:0]  denom_w;
  logic [REM_W:0]    trial;
  logic              qbit;
  logic [REM_W-1:0]  rem_keep;

  logic signed [PROD_W-1:0]   rnd;
  logic signed [PROD_W-1:0]   corr;
  logic signed [DIFF_W+1:0]   est_sum;
  logic signed [MEAS_W-1:0]   est_clamp;
  logic signed [DIFF_W-1:0]   est_delta;

  logic [ERR_W+FRAC_W-1-8:0] noise;
  logic [ERR_W+FRAC_W-8:0]   err_sum;
  logic [ERR_W-1:0]          err_sat;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign commit   = (state_r == ST_DONE) && out_free;

  assign cfg_ch.ready = 1'b1;

  // gain is forced to zero on a zero denominator
  assign gain_w  = fault_r ? '0 : quo_r;
  assign denom_w = {1'b0, err_r} + {1'b0, meas_err_r};

  // one restoring division step
  assign trial    = {1'b0, rem_r} - {2'b0, denom_r};
  assign qbit     = !trial[REM_W];
  assign rem_keep = qbit ? trial[REM_W-1:0] : rem_r;

  // shared multiplier
  assign mul_p = mul_a * mul_b;

  // round half up back to Q8.8, then clamp to the estimate range
  assign rnd       = prod_r + PROD_W'(32768);
  assign corr      = rnd >>> FRAC_W;
  assign est_sum   = (DIFF_W+2)'(last_r) + (DIFF_W+2)'(corr);
  assign est_clamp = (est_sum > (DIFF_W+2)'(32767))  ? 16'sh7fff :
                     (est_sum < -(DIFF_W+2)'(32768)) ? 16'sh8000 :
                     est_sum[MEAS_W-1:0];
  assign est_delta = DIFF_W'(est_clamp) - DIFF_W'(last_r);

  // noise term is Q8.8 times Q16.16, taken back to Q16.16
  assign noise   = prod_r[ERR_W+FRAC_W-1:8];
  assign err_sum = {{(FRAC_W-8+1){1'b0}}, decay_r} + {1'b0, noise};
  assign err_sat = (err_sum[ERR_W+FRAC_W-8:ERR_W] != '0) ? '1 : err_sum[ERR_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_ch.valid) state_nxt = ST_DIV;
      ST_DIV:       if (cnt_r == '0) state_nxt = ST_MUL_CORR;
      ST_MUL_CORR:  state_nxt = ST_EST;
      ST_EST:       state_nxt = ST_MUL_DECAY;
      ST_MUL_DECAY: state_nxt = ST_MUL_NOISE;
      ST_MUL_NOISE: state_nxt = ST_DONE;
      ST_DONE:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: input handshake and multiplier operands
  always_comb begin
    in_ch.ready = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    unique case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_MUL_CORR: begin
        mul_a = MUL_A_W'(gain_w);
        mul_b = MUL_B_W'(diff_r);
      end
      ST_MUL_DECAY: begin
        mul_a = MUL_A_W'(ONE_Q16 - gain_w);
        mul_b = MUL_B_W'(err_r);
      end
      ST_MUL_NOISE: begin
        mul_a = MUL_A_W'(absd_r);
        mul_b = MUL_B_W'(proc_noise_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_err_r   <= MEAS_ERR_RESET;
      proc_noise_r <= PROC_NOISE_RESET;
      last_r       <= '0;
      err_r        <= INIT_ERR_RESET;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.reg_index)
          CFG_MEAS_ERR:   meas_err_r <= cfg_ch.wdata;
          CFG_INIT_ERR:   err_r <= cfg_ch.wdata;
          CFG_PROC_NOISE: proc_noise_r <= cfg_ch.wdata;
          default: ;
        endcase
      end
      if (commit) begin
        last_r <= est_r;
        err_r  <= err_sat;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        // latch the beat and seed the divider
        diff_r  <= DIFF_W'(in_ch.measurement) - DIFF_W'(last_r);
        denom_r <= denom_w;
        fault_r <= (denom_w == '0);
        rem_r   <= {2'b0, err_r};
        quo_r   <= '0;
        cnt_r   <= CNT_W'(DIV_STEPS - 1);
      end
      ST_DIV: begin
        quo_r <= {quo_r[GAIN_W-2:0], qbit};
        rem_r <= {rem_keep[REM_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
      end
      ST_MUL_CORR: prod_r <= mul_p;
      ST_EST: begin
        est_r  <= est_clamp;
        absd_r <= est_delta[DIFF_W-1] ? DIFF_W'(-est_delta) : DIFF_W'(est_delta);
      end
      ST_MUL_DECAY: prod_r <= mul_p;
      ST_MUL_NOISE: begin
        decay_r <= prod_r[ERR_W+FRAC_W-1:FRAC_W];
        prod_r  <= mul_p;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // output register: load on commit, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_est_r   <= est_r;
      out_gain_r  <= gain_w;
      out_err_r   <= err_sat;
      out_fault_r <= fault_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.estimate     = out_est_r;
  assign out_ch.gain         = out_gain_r;
  assign out_ch.error_out    = out_err_r;
  assign out_ch.divide_fault = out_fault_r;

endmodule

### hdl/skf_checker.sv
// Port-level checks of the scalar Kalman estimator and their bind to the top level.
module skf_checker import skf_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [MEAS_W-1:0] out_estimate,
  input logic        [GAIN_W-1:0] out_gain,
  input logic                     out_divide_fault
);

  // no result beat right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a measurement beat keeps the block busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a measurement beat");

  // gain never exceeds 1.0
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_gain <= ONE_Q16)
    else $error("gain above 1.0");

  // a divide fault carries a zero gain
  a_fault_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_fault |-> out_gain == '0)
    else $error("divide fault with nonzero gain");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_estimate))
    else $error("stalled result beat changed");

endmodule

bind scalar_kalman_estimator_top skf_checker u_skf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_estimate     (out_ch.estimate),
  .out_gain         (out_ch.gain),
  .out_divide_fault (out_ch.divide_fault)
);
